FILE: design/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants of the MFM byte deframer
// Register indexes, mark codes, configuration bundle, request and result items.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int unsigned CELLS_PER_BYTE = 16;
   localparam int unsigned COUNT_W        = 5;
   localparam int unsigned HIST_W         = 64;
   localparam int unsigned MARK_W         = 16;
   localparam int unsigned CSR_INDEX_W    = 8;
   localparam int unsigned CSR_DATA_W     = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MARK_A1 = 8'd0,
      CSR_MARK_C2 = 8'd1,
      CSR_MARK_14 = 8'd2,
      CSR_MARK_28 = 8'd3,
      CSR_SYNC    = 8'd4
   } csr_index_type;

   localparam logic [7:0] MARK_CODE_14 = 8'h14;
   localparam logic [7:0] MARK_CODE_28 = 8'h28;
   localparam logic [7:0] MARK_CODE_A1 = 8'ha1;
   localparam logic [7:0] MARK_CODE_C2 = 8'hc2;

   localparam logic [MARK_W-1:0] MARK_A1_RESET = 16'h4489;
   localparam logic [MARK_W-1:0] MARK_C2_RESET = 16'h5224;
   localparam logic [MARK_W-1:0] MARK_14_RESET = 16'h2244;
   localparam logic [MARK_W-1:0] MARK_28_RESET = 16'h2912;
   localparam logic [HIST_W-1:0] SYNC_RESET    = 64'haaaa_aaaa_aaaa_aaaa;

   typedef struct packed {
      logic [MARK_W-1:0] mark_a1_pattern;
      logic [MARK_W-1:0] mark_c2_pattern;
      logic [MARK_W-1:0] mark_14_pattern;
      logic [MARK_W-1:0] mark_28_pattern;
      logic [HIST_W-1:0] sync_pattern;
   } cfg_type;

   typedef struct packed {
      logic skip_sync_detect;
      logic skip_mark_detect;
      logic cell_bit;
   } req_item_type;

   typedef struct packed {
      logic       pll_gain_high;
      logic       mark_found;
      logic [7:0] data_byte;
      logic       byte_done;
   } rsp_item_type;

endpackage

FILE: design/mfm_byte_deframer_unit.sv
// ----------------------------------------------------------------------------
// mfm_byte_deframer_unit: MFM byte deframer with missing-clock mark sync
// Takes one separated cell bit per request and reports per cell whether a
// byte or a missing-clock mark completed, with its value and the gain request.
//
// Request channel (req_): one cell bit with two detect-disable flags.
// Result channel (rsp_): exactly one result per request, in order.
// Configuration (csr_): index 0..4 selects A1, C2, 14, 28 and sync patterns;
//   csr_ready is always high, other indexes are dropped. Write only when idle.
// Path: request register, core logic, result register; rsp_ shows the registered result.
// Throughput: one request per cycle unless rsp_ stalls; history compare, mark
//   priority and count update are one pass of logic between the two registers.
// Reset: history, counter, decay and gain flags clear; patterns return to
//   their default mark and sync values; both channels come up empty.
// Stall: a held result keeps rsp_ stable; one more request is held in the
//   request register, after which req_tready drops until rsp_tready returns.
// ----------------------------------------------------------------------------
module mfm_byte_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] cell_bit, [1] skip_mark_detect,
                                    // [2] skip_sync_detect, [7:3] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [8] pll_gain_high, [15:9] zero
   output logic [0:0]  rsp_tuser,   // [0] mark_found
   output logic        rsp_tlast,   // byte_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);

   mbd_pkg::cfg_type      cfg;
   mbd_pkg::req_item_type req_item_ff, req_item_in;
   mbd_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   mbd_pkg::rsp_item_type core_rsp;
   logic                  req_valid_ff, req_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;

   mbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cfg      (cfg),
      .req_item (req_item_ff),
      .rsp_item (core_rsp)
   );

   always_comb begin
      advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !req_valid_ff || advance;

      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
         req_item_in  = req_tdata[2:0];
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {7'd0, rsp_item_ff.pll_gain_high, rsp_item_ff.data_byte};
   assign rsp_tuser[0] = rsp_item_ff.mark_found;
   assign rsp_tlast    = rsp_item_ff.byte_done;

endmodule

FILE: design/mbd_csr.sv
// ----------------------------------------------------------------------------
// mbd_csr: configuration registers
// Holds the four mark patterns and the sync pattern; writes are always taken.
// ----------------------------------------------------------------------------
module mbd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]      csr_data,
   output mbd_pkg::cfg_type                    cfg
);

   mbd_pkg::cfg_type cfg_ff;
   mbd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mbd_pkg::CSR_MARK_A1: begin
               cfg_in.mark_a1_pattern = csr_data[mbd_pkg::MARK_W-1:0];
            end
            mbd_pkg::CSR_MARK_C2: begin
               cfg_in.mark_c2_pattern = csr_data[mbd_pkg::MARK_W-1:0];
            end
            mbd_pkg::CSR_MARK_14: begin
               cfg_in.mark_14_pattern = csr_data[mbd_pkg::MARK_W-1:0];
            end
            mbd_pkg::CSR_MARK_28: begin
               cfg_in.mark_28_pattern = csr_data[mbd_pkg::MARK_W-1:0];
            end
            mbd_pkg::CSR_SYNC: begin
               cfg_in.sync_pattern = csr_data[mbd_pkg::HIST_W-1:0];
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mark_a1_pattern <= mbd_pkg::MARK_A1_RESET;
         cfg_ff.mark_c2_pattern <= mbd_pkg::MARK_C2_RESET;
         cfg_ff.mark_14_pattern <= mbd_pkg::MARK_14_RESET;
         cfg_ff.mark_28_pattern <= mbd_pkg::MARK_28_RESET;
         cfg_ff.sync_pattern    <= mbd_pkg::SYNC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/mbd_core.sv
// ----------------------------------------------------------------------------
// mbd_core: cell history, byte counter and mark / sync detection
// Computes one result per cell from the held request and updates state on advance.
// ----------------------------------------------------------------------------
module mbd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  mbd_pkg::cfg_type       cfg,
   input  mbd_pkg::req_item_type  req_item,
   output mbd_pkg::rsp_item_type  rsp_item
);

   logic [mbd_pkg::HIST_W-1:0]  hist_ff,  hist_in;
   logic [mbd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        a1_decay_ff, a1_decay_in;
   logic                        c2_decay_ff, c2_decay_in;
   logic                        gain_ff, gain_in;

   logic [mbd_pkg::HIST_W-1:0]  hist_next;
   logic [mbd_pkg::MARK_W-1:0]  low_old;
   logic [mbd_pkg::MARK_W-1:0]  low_new;
   logic [mbd_pkg::COUNT_W-1:0] count_step;
   logic [mbd_pkg::COUNT_W-1:0] count_sync;
   logic                        byte_start;
   logic                        even;
   logic                        mark_hit;
   logic [7:0]                  mark_code;
   logic [7:0]                  data_cells;

   always_comb begin
      byte_start  = (count_ff == '0);
      low_old     = hist_ff[mbd_pkg::MARK_W-1:0];
      a1_decay_in = byte_start ? (low_old == cfg.mark_14_pattern) : a1_decay_ff;
      c2_decay_in = byte_start ? (low_old == cfg.mark_28_pattern) : c2_decay_ff;

      hist_next  = {hist_ff[mbd_pkg::HIST_W-2:0], req_item.cell_bit};
      count_step = count_ff + mbd_pkg::COUNT_W'(1);
      low_new    = hist_next[mbd_pkg::MARK_W-1:0];
      even       = ~count_step[0];

      // data cells sit at even history positions, MSB at bit 14
      for (int i = 0; i < 8; i++) begin
         data_cells[i] = hist_next[2*i];
      end

      mark_hit  = 1'b0;
      mark_code = mbd_pkg::MARK_CODE_14;
      if (!req_item.skip_mark_detect) begin
         priority if (low_new == cfg.mark_14_pattern && even) begin
            mark_hit  = 1'b1;
            mark_code = mbd_pkg::MARK_CODE_14;
         end else if (low_new == cfg.mark_28_pattern && even) begin
            mark_hit  = 1'b1;
            mark_code = mbd_pkg::MARK_CODE_28;
         end else if (low_new == cfg.mark_a1_pattern && (even || a1_decay_in)) begin
            mark_hit  = 1'b1;
            mark_code = mbd_pkg::MARK_CODE_A1;
         end else if (low_new == cfg.mark_c2_pattern && (even || c2_decay_in)) begin
            mark_hit  = 1'b1;
            mark_code = mbd_pkg::MARK_CODE_C2;
         end else begin
            mark_hit  = 1'b0;
         end
      end

      hist_in    = hist_next;
      gain_in    = gain_ff;
      count_sync = count_step;
      rsp_item   = '0;

      if (mark_hit) begin
         // mark ends the byte; gain request holds
         count_in           = '0;
         rsp_item.byte_done  = 1'b1;
         rsp_item.data_byte  = mark_code;
         rsp_item.mark_found = 1'b1;
      end else begin
         if (!req_item.skip_sync_detect) begin
            if (hist_next == cfg.sync_pattern) begin
               // realign clock/data phase
               count_sync = {count_step[mbd_pkg::COUNT_W-1:1], 1'b0};
               gain_in    = 1'b1;
            end else begin
               gain_in = 1'b0;
            end
         end
         if (count_sync >= mbd_pkg::COUNT_W'(mbd_pkg::CELLS_PER_BYTE)) begin
            count_in           = '0;
            rsp_item.byte_done = 1'b1;
            rsp_item.data_byte = data_cells;
         end else begin
            count_in = count_sync;
         end
      end
      rsp_item.pll_gain_high = gain_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         count_ff    <= '0;
         a1_decay_ff <= 1'b0;
         c2_decay_ff <= 1'b0;
         gain_ff     <= 1'b0;
      end else if (advance) begin
         hist_ff     <= hist_in;
         count_ff    <= count_in;
         a1_decay_ff <= a1_decay_in;
         c2_decay_ff <= c2_decay_in;
         gain_ff     <= gain_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < mbd_pkg::COUNT_W'(mbd_pkg::CELLS_PER_BYTE))
      else $error("cell count left the byte range");

   a_done_clears_count: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_item.byte_done |=> count_ff == '0)
      else $error("cell count not cleared after a finished byte");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(hist_ff) && $stable(count_ff) && $stable(gain_ff))
      else $error("state changed without an advancing request");

   a_mark_keeps_gain: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_item.mark_found |=> gain_ff == $past(gain_ff))
      else $error("gain request changed on a mark");
`endif

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the MFM byte deframer unit
// Streams MFM cell bits (sync runs, mark patterns, encoded data bytes, noise
// and phase slips) through the request channel under random gaps and stalls.
// A cycle-free model of the deframer predicts every result, and the monitor
// compares each result field by field, in order. Pattern registers are
// rewritten between traffic phases, including all-zero and all-one settings.
// ----------------------------------------------------------------------------
module tb;
   import mbd_pkg::*;

   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned HOLD_AT_CELL  = 500;
   localparam logic [7:0]  CSR_NO_REG    = 8'hff;

   typedef enum int {GAP_RANDOM, GAP_NONE, GAP_RARE} gap_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // deframer shadow state and pattern registers
   cfg_type     dfr_cfg = '{MARK_A1_RESET, MARK_C2_RESET, MARK_14_RESET,
                            MARK_28_RESET, SYNC_RESET};
   logic [63:0] dfr_history = '0;
   logic [4:0]  dfr_count = '0;
   logic        dfr_a1_decay = 1'b0;
   logic        dfr_c2_decay = 1'b0;
   logic        dfr_gain = 1'b0;

   req_item_type cell_queue[$];
   rsp_item_type result_queue[$];
   rsp_item_type want;

   gap_mode_type req_mode = GAP_RANDOM;
   gap_mode_type rsp_mode = GAP_RANDOM;
   int  req_wait = 0;
   int  rsp_wait = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;
   int  quiet_cycles = 0;

   int  cells_queued = 0;
   int  cells_checked = 0;
   int  fail_count = 0;
   int  byte_count = 0;
   int  mark_count = 0;
   int  gain_count = 0;
   int  setting_count = 1;
   logic prev_data = 1'b0;

   mfm_byte_deframer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap(gap_mode_type mode);
      case (mode)
         GAP_NONE: return 0;
         GAP_RARE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
         default:  return $urandom_range(0, 16);
      endcase
   endfunction

   // one cell through the deframer: shift, mark search, sync search, byte count
   function automatic rsp_item_type advance_deframer(req_item_type cell_item);
      rsp_item_type res;
      logic [15:0]  low_cells;
      logic         even;
      logic         hit;
      logic [7:0]   code;
      int           k;
      res  = '0;
      hit  = 1'b0;
      code = '0;
      if (dfr_count == 0) begin
         dfr_a1_decay = (dfr_history[15:0] == dfr_cfg.mark_14_pattern);
         dfr_c2_decay = (dfr_history[15:0] == dfr_cfg.mark_28_pattern);
      end
      dfr_history = {dfr_history[62:0], cell_item.cell_bit};
      dfr_count   = dfr_count + 5'd1;
      low_cells   = dfr_history[15:0];
      even        = ~dfr_count[0];
      if (!cell_item.skip_mark_detect) begin
         if (low_cells == dfr_cfg.mark_14_pattern && even) begin
            hit = 1'b1;
            code = MARK_CODE_14;
         end else if (low_cells == dfr_cfg.mark_28_pattern && even) begin
            hit = 1'b1;
            code = MARK_CODE_28;
         end else if (low_cells == dfr_cfg.mark_a1_pattern && (even || dfr_a1_decay)) begin
            hit = 1'b1;
            code = MARK_CODE_A1;
         end else if (low_cells == dfr_cfg.mark_c2_pattern && (even || dfr_c2_decay)) begin
            hit = 1'b1;
            code = MARK_CODE_C2;
         end
      end
      if (hit) begin
         dfr_count         = '0;
         res.byte_done     = 1'b1;
         res.data_byte     = code;
         res.mark_found    = 1'b1;
         res.pll_gain_high = dfr_gain;
         return res;
      end
      if (!cell_item.skip_sync_detect) begin
         if (dfr_history == dfr_cfg.sync_pattern) begin
            dfr_count[0] = 1'b0;    // realign clock/data phase
            dfr_gain     = 1'b1;
         end else begin
            dfr_gain = 1'b0;
         end
      end
      if (dfr_count >= CELLS_PER_BYTE) begin
         dfr_count     = '0;
         res.byte_done = 1'b1;
         for (k = 0; k < 8; k++) res.data_byte[k] = dfr_history[2*k];
      end
      res.pll_gain_high = dfr_gain;
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (req_fire || !req_tvalid)) begin
         if (req_wait > 0) begin
            req_tvalid <= 1'b0;
            req_wait   <= req_wait - 1;
         end else if (cell_queue.size() != 0) begin
            req_tdata  <= {5'd0, cell_queue.pop_front()};
            req_tvalid <= 1'b1;
            req_wait   <= pick_gap(req_mode);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) rsp_wait = pick_gap(rsp_mode);
         if (!hold_done && cells_checked >= HOLD_AT_CELL) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait   = rsp_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      rsp_fire <= rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready)
         result_queue.push_back(advance_deframer(req_item_type'(req_tdata[2:0])));
      if (!reset && rsp_tvalid && rsp_tready) begin
         cells_checked++;
         if (result_queue.size() == 0) begin
            $error("result arrived with no cell pending");
            fail_count++;
         end else begin
            want = result_queue.pop_front();
            if (rsp_tlast !== want.byte_done) begin
               $error("byte_done expected %0d got %0d", want.byte_done, rsp_tlast);
               fail_count++;
            end
            if (rsp_tdata[7:0] !== want.data_byte) begin
               $error("data_byte expected %02h got %02h", want.data_byte, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tuser[0] !== want.mark_found) begin
               $error("mark_found expected %0d got %0d", want.mark_found, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tdata[8] !== want.pll_gain_high) begin
               $error("pll_gain_high expected %0d got %0d", want.pll_gain_high, rsp_tdata[8]);
               fail_count++;
            end
            if (want.byte_done && !want.mark_found) byte_count++;
            if (want.mark_found) mark_count++;
            if (want.pll_gain_high) gain_count++;
         end
      end
   end

   // watchdog: any handshake counts as progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic push_cell(input logic b, input logic skip_mark, input logic skip_sync);
      req_item_type cell_item;
      cell_item.cell_bit         = b;
      cell_item.skip_mark_detect = skip_mark;
      cell_item.skip_sync_detect = skip_sync;
      cell_queue.push_back(cell_item);
      cells_queued++;
   endtask

   // mostly detection on, now and then a disabled detector
   task automatic push_noisy(input logic b);
      push_cell(b, $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
   endtask

   task automatic push_bits(input logic [63:0] bits, input int count);
      int i;
      for (i = count - 1; i >= 0; i--) push_noisy(bits[i]);
   endtask

   task automatic push_mfm_byte(input logic [7:0] value);
      int i;
      for (i = 7; i >= 0; i--) begin
         push_noisy(~(prev_data | value[i]));
         push_noisy(value[i]);
         prev_data = value[i];
      end
   endtask

   // well-formed track fragments with random content, plus noise and slips
   task automatic queue_traffic(input int count);
      int stop_at;
      int roll;
      int i;
      logic [15:0] pat;
      stop_at = cells_queued + count;
      while (cells_queued < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            for (i = $urandom_range(8, 40); i > 0; i--) begin
               push_noisy(1'b1);
               push_noisy(1'b0);
            end
         end else if (roll < 20) begin
            push_bits(dfr_cfg.sync_pattern, 64);
         end else if (roll < 45) begin
            case ($urandom_range(0, 3))
               0: pat = dfr_cfg.mark_a1_pattern;
               1: pat = dfr_cfg.mark_c2_pattern;
               2: pat = dfr_cfg.mark_14_pattern;
               default: pat = dfr_cfg.mark_28_pattern;
            endcase
            push_bits({48'd0, pat}, 16);
         end else if (roll < 80) begin
            push_mfm_byte(8'($urandom));
         end else if (roll < 92) begin
            push_bits({$urandom, $urandom}, $urandom_range(1, 20));
         end else begin
            push_noisy($urandom_range(0, 1));
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (cells_checked < cells_queued);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [7:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_MARK_A1: dfr_cfg.mark_a1_pattern = value[15:0];
         CSR_MARK_C2: dfr_cfg.mark_c2_pattern = value[15:0];
         CSR_MARK_14: dfr_cfg.mark_14_pattern = value[15:0];
         CSR_MARK_28: dfr_cfg.mark_28_pattern = value[15:0];
         CSR_SYNC:    dfr_cfg.sync_pattern    = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_patterns(input logic [15:0] a1, input logic [15:0] c2,
                                 input logic [15:0] m14, input logic [15:0] m28,
                                 input logic [63:0] sync);
      wait_drained();
      write_csr(CSR_MARK_A1, {$urandom, $urandom} & 64'hffff_ffff_ffff_0000 | a1);
      write_csr(CSR_MARK_C2, {48'd0, c2});
      write_csr(CSR_MARK_14, {48'd0, m14});
      write_csr(CSR_MARK_28, {48'd0, m28});
      write_csr(CSR_SYNC, sync);
      write_csr(CSR_NO_REG, {$urandom, $urandom});
      setting_count++;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default A1 mark from a clean history, then every flag combination
      push_bits({48'd0, MARK_A1_RESET}, 16);
      push_cell(1'b1, 1'b1, 1'b0);
      push_cell(1'b0, 1'b0, 1'b1);
      push_cell(1'b1, 1'b1, 1'b1);
      push_cell(1'b0, 1'b0, 1'b0);
      push_cell(1'b1, 1'b0, 1'b0);
      push_cell(1'b0, 1'b1, 1'b1);
      queue_traffic(400);

      write_patterns(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     {$urandom, $urandom});
      req_mode = GAP_NONE;
      queue_traffic(350);

      write_patterns(16'hffff, 16'h0000, 16'h0000, 16'hffff, 64'hffff_ffff_ffff_ffff);
      req_mode = GAP_RANDOM;
      rsp_mode = GAP_NONE;
      queue_traffic(300);

      write_patterns(16'h0000, 16'hffff, 16'hffff, 16'h0000, 64'd0);
      rsp_mode = GAP_RANDOM;
      queue_traffic(250);

      write_patterns(MARK_A1_RESET, MARK_C2_RESET, MARK_14_RESET, MARK_28_RESET, SYNC_RESET);
      req_mode = GAP_RARE;
      rsp_mode = GAP_RARE;
      queue_traffic(500);

      wait_drained();
      $display("run covered %0d cells: %0d data bytes, %0d marks, %0d cells at high gain",
               cells_checked, byte_count, mark_count, gain_count);
      $display("over %0d pattern settings, all-zero and all-one patterns included",
               setting_count);
      if (fail_count == 0 && result_queue.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
